/* hw/rtl/qcrc_pkg.sv */
// shared types and constants for the quadrature counter with read-and-clear banks
`timescale 1ns / 1ps
`default_nettype none

package qcrc_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int REPLY_W     = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int DELTA_W     = 3;

    localparam logic [BYTE_BITS-1:0] PWM_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_CMD    = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        CMD_OTHER = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_MOTOR = 3'd2,
        CMD_READ  = 3'd3,
        CMD_IDENT = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_1X = 2'd0,
        MODE_2X = 2'd1,
        MODE_4X = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_COUNT_MODE  = 2'd0,
        CFG_INVERT_SIGN = 2'd1,
        CFG_PWM_OFFSET  = 2'd2,
        CFG_VERSION     = 2'd3
    } t_cfg_idx;

    // control from the command stage to the counter banks
    typedef struct packed {
        logic                      tick;
        logic signed [DELTA_W-1:0] delta;
        logic                      clear_all;
        logic                      read_clear;
    } t_bank_ctl;

endpackage

`default_nettype wire

/* hw/rtl/quadrature_counter_read_clear.sv */
// top level: request and reply streams, configuration, command handling
//
// quadrature counter with read-and-clear double banking
// slave stream: one request per cycle while o_s_tready is high, tuser holds the operation (sample tick,
//   command write, bus read), tdata holds pin levels, command code and data
// master stream: exactly one reply per request, tuser holds the reply kind,
//   tdata holds reply valid flag, reply value and current pwm level
// config channel: register index and data, always ready, write only while idle
// flow: an accepted request passes the request register, then the reply register,
//   to o_m_tvalid; throughput is one request per cycle while the reply stream does
//   not stall, set by the single request register feeding counter and command update
// stall: when i_m_tready is low the reply register holds, the request
//   register fills, then o_s_tready drops; nothing is lost or repeated
// reset: i_rst_n low clears both counters, bank select, the pending command,
//   the pwm level and the pipeline; configuration returns to 4x counting,
//   no inversion, zero pwm offset and version code 1
//
`timescale 1ns / 1ps
`default_nettype none

module quadrature_counter_read_clear
    import qcrc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    input  wire  [IN_TDATA_W-1:0]  i_s_tdata,  // pin_a, pin_b, command_code, command_data
    input  wire  [1:0]             i_s_tuser,  // operation
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,  // reply_valid, reply_value, pwm_level
    output logic                   o_m_tuser,  // reply_kind
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [1:0]             i_cfg_index,
    input  wire  [BYTE_BITS-1:0]   i_cfg_data
);

    // configuration
    logic [1:0]           r_count_mode;
    logic                 r_invert;
    logic [BYTE_BITS-1:0] r_pwm_offset;
    logic [BYTE_BITS-1:0] r_version;

    // request register
    logic                 r_in_valid;
    logic [1:0]           r_op;
    logic                 r_pin_a;
    logic                 r_pin_b;
    logic [2:0]           r_code;
    logic [BYTE_BITS-1:0] r_data;

    // command state
    logic [2:0]           r_pending;
    logic [2:0]           n_pending;
    logic [BYTE_BITS-1:0] r_pwm;
    logic [BYTE_BITS-1:0] n_pwm;

    // reply register
    logic                 r_out_valid;
    logic                 r_reply_valid;
    logic                 r_reply_kind;
    logic [REPLY_W-1:0]   r_reply_value;
    logic [BYTE_BITS-1:0] r_pwm_level;
    logic                 n_reply_valid;
    logic                 n_reply_kind;
    logic [REPLY_W-1:0]   n_reply_value;

    logic                          w_adv;
    t_bank_ctl                     w_ctl;
    logic signed [DELTA_W-1:0]     w_delta;
    logic [COUNT_WIDTH-1:0]        w_active;
    logic [COUNT_WIDTH-1:0]        w_read_cnt;
    logic signed [31:0]            w_read_ext;
    logic [BYTE_BITS:0]            w_pwm_sum;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_mode <= MODE_4X;
            r_invert     <= 1'b0;
            r_pwm_offset <= '0;
            r_version    <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COUNT_MODE:  r_count_mode <= i_cfg_data[1:0];
                CFG_INVERT_SIGN: r_invert     <= i_cfg_data[0];
                CFG_PWM_OFFSET:  r_pwm_offset <= i_cfg_data;
                CFG_VERSION:     r_version    <= i_cfg_data;
                default:         r_version    <= r_version;
            endcase
        end
    end

    // pipeline flow
    assign w_adv      = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_op    <= i_s_tuser;
            r_pin_a <= i_s_tdata[0];
            r_pin_b <= i_s_tdata[1];
            r_code  <= i_s_tdata[4:2];
            r_data  <= i_s_tdata[12:5];
        end
    end

    qcrc_dir u_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_ctl.tick),
        .i_pin_a (r_pin_a),
        .i_pin_b (r_pin_b),
        .i_mode  (r_count_mode),
        .o_delta (w_delta)
    );

    qcrc_bank #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .o_active (w_active)
    );

    assign w_read_cnt = r_invert ? (~w_active + 1'b1) : w_active;
    assign w_read_ext = 32'(signed'(w_read_cnt));
    assign w_pwm_sum  = {1'b0, r_data} + {1'b0, r_pwm_offset};

    always_comb begin
        w_ctl.tick       = 1'b0;
        w_ctl.delta      = w_delta;
        w_ctl.clear_all  = 1'b0;
        w_ctl.read_clear = 1'b0;
        n_pending        = r_pending;
        n_pwm            = r_pwm;
        n_reply_valid    = 1'b0;
        n_reply_kind     = 1'b0;
        n_reply_value    = '0;
        if (w_adv) begin
            unique case (t_op'(r_op))
                OP_SAMPLE: begin
                    w_ctl.tick = 1'b1;
                end
                OP_CMD: begin
                    if (r_code == CMD_CLEAR) begin
                        w_ctl.clear_all = 1'b1;
                        n_pending       = CMD_OTHER;
                    end else if (r_code == CMD_MOTOR) begin
                        n_pwm     = w_pwm_sum[BYTE_BITS] ? PWM_MAX : w_pwm_sum[BYTE_BITS-1:0];
                        n_pending = CMD_OTHER;
                    end else begin
                        n_pending = r_code;
                    end
                end
                OP_READ: begin
                    if (r_pending == CMD_READ) begin
                        w_ctl.read_clear = 1'b1;
                        n_reply_valid    = 1'b1;
                        n_reply_value    = w_read_ext[REPLY_W-1:0];
                    end else if (r_pending == CMD_IDENT) begin
                        n_reply_valid = 1'b1;
                        n_reply_kind  = 1'b1;
                        n_reply_value = {{(REPLY_W-BYTE_BITS){1'b0}}, r_version};
                    end
                    n_pending = CMD_OTHER;
                end
                default: begin
                    n_pending = r_pending;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= CMD_OTHER;
            r_pwm     <= '0;
        end else begin
            r_pending <= n_pending;
            r_pwm     <= n_pwm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_reply_valid <= n_reply_valid;
            r_reply_kind  <= n_reply_kind;
            r_reply_value <= n_reply_value;
            r_pwm_level   <= n_pwm;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_reply_kind;
    assign o_m_tdata  = {{(OUT_TDATA_W-1-REPLY_W-BYTE_BITS){1'b0}},
                         r_pwm_level, r_reply_value, r_reply_valid};

endmodule

`default_nettype wire

/* hw/rtl/qcrc_dir.sv */
// encoder edge detector and direction decoder, one signed delta per sample
`timescale 1ns / 1ps
`default_nettype none

module qcrc_dir
    import qcrc_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_tick,
    input  wire                       i_pin_a,
    input  wire                       i_pin_b,
    input  wire  [1:0]                i_mode,
    output logic signed [DELTA_W-1:0] o_delta
);

    logic r_last_a;
    logic r_last_b;
    logic w_edge_a;
    logic w_edge_b;
    logic w_count_a;
    logic w_count_b;
    logic signed [DELTA_W-1:0] w_step_a;
    logic signed [DELTA_W-1:0] w_step_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a <= 1'b0;
            r_last_b <= 1'b0;
        end else if (i_tick) begin
            r_last_a <= i_pin_a;
            r_last_b <= i_pin_b;
        end
    end

    assign w_edge_a = i_pin_a ^ r_last_a;
    assign w_edge_b = i_pin_b ^ r_last_b;

    always_comb begin
        unique case (t_mode'(i_mode))
            MODE_1X: begin
                w_count_a = w_edge_a & i_pin_a;
                w_count_b = 1'b0;
            end
            MODE_2X: begin
                w_count_a = w_edge_a & i_pin_a;
                w_count_b = w_edge_b & i_pin_b;
            end
            default: begin
                w_count_a = w_edge_a;
                w_count_b = w_edge_b;
            end
        endcase
    end

    // a edge counts up when a differs from b, b edge counts up when b equals a
    always_comb begin
        w_step_a = '0;
        w_step_b = '0;
        if (w_count_a) begin
            w_step_a = (i_pin_a != i_pin_b) ? 3'sd1 : -3'sd1;
        end
        if (w_count_b) begin
            w_step_b = (i_pin_a == i_pin_b) ? 3'sd1 : -3'sd1;
        end
    end

    assign o_delta = w_step_a + w_step_b;

endmodule

`default_nettype wire

/* hw/rtl/qcrc_bank.sv */
// two wrapping count banks with read-and-clear bank swap
`timescale 1ns / 1ps
`default_nettype none

module qcrc_bank
    import qcrc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_bank_ctl              i_ctl,
    output logic [COUNT_WIDTH-1:0] o_active
);

    logic [COUNT_WIDTH-1:0] r_bank0;
    logic [COUNT_WIDTH-1:0] r_bank1;
    logic                   r_sel;
    logic [COUNT_WIDTH-1:0] n_bank0;
    logic [COUNT_WIDTH-1:0] n_bank1;
    logic                   n_sel;
    logic [COUNT_WIDTH-1:0] w_delta_ext;

    assign o_active    = r_sel ? r_bank1 : r_bank0;
    assign w_delta_ext = {{(COUNT_WIDTH-DELTA_W){i_ctl.delta[DELTA_W-1]}}, i_ctl.delta};

    always_comb begin
        n_bank0 = r_bank0;
        n_bank1 = r_bank1;
        n_sel   = r_sel;
        if (i_ctl.clear_all) begin
            n_bank0 = '0;
            n_bank1 = '0;
            n_sel   = 1'b0;
        end else if (i_ctl.read_clear) begin
            if (r_sel) begin
                n_bank1 = '0;
            end else begin
                n_bank0 = '0;
            end
            n_sel = ~r_sel;
        end else if (i_ctl.tick) begin
            if (r_sel) begin
                n_bank1 = r_bank1 + w_delta_ext;
            end else begin
                n_bank0 = r_bank0 + w_delta_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank0 <= '0;
            r_bank1 <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_bank0 <= n_bank0;
            r_bank1 <= n_bank1;
            r_sel   <= n_sel;
        end
    end

endmodule

`default_nettype wire

/* tb/tb_quadrature_counter_read_clear.sv */
// testbench for the quadrature counter with read-and-clear banks, checked against a local predictor
`timescale 1ns / 1ps

module tb_quadrature_counter_read_clear;
    import qcrc_pkg::*;

    typedef struct {
        logic [1:0]           op;
        logic                 a;
        logic                 b;
        logic [2:0]           code;
        logic [BYTE_BITS-1:0] data;
    } t_sample_req;

    typedef struct {
        logic                 valid;
        logic                 kind;
        logic [REPLY_W-1:0]   value;
        logic [BYTE_BITS-1:0] pwm;
    } t_reply;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic [1:0]             i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index = '0;
    logic [BYTE_BITS-1:0]   i_cfg_data = '0;

    quadrature_counter_read_clear u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // counter state mirrored by the predictor
    logic [1:0]           cfg_mode = MODE_4X;
    logic                 cfg_invert = 1'b0;
    logic [BYTE_BITS-1:0] cfg_offset = '0;
    logic [BYTE_BITS-1:0] cfg_version = 8'd1;
    logic                 last_a = 1'b0;
    logic                 last_b = 1'b0;
    logic [REPLY_W-1:0]   count_bank [2] = '{default: '0};
    logic                 bank_sel = 1'b0;
    logic [2:0]           pend_cmd = CMD_OTHER;
    logic [BYTE_BITS-1:0] pwm_level = '0;

    t_sample_req req_queue[$];
    t_reply      reply_expect_q[$];
    t_sample_req req_on_bus;
    int          err_count = 0;
    int          req_accepted = 0;
    int          hold_at = -1;
    int          rx_hold_cnt = 0;
    bit          hold_done = 1'b0;
    bit          no_idle = 1'b0;
    logic        pin_a = 1'b0;
    logic        pin_b = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_reply predict_reply(input t_sample_req r);
        t_reply             rep;
        logic               a_moved;
        logic               b_moved;
        logic               cnt_a;
        logic               cnt_b;
        logic [REPLY_W-1:0] v;
        logic [BYTE_BITS:0] lvl;
        rep = '{valid: 1'b0, kind: 1'b0, value: '0, pwm: '0};
        case (r.op)
            OP_SAMPLE: begin
                a_moved = r.a != last_a;
                b_moved = r.b != last_b;
                if (cfg_mode == MODE_1X) begin
                    cnt_a = a_moved && r.a;
                    cnt_b = 1'b0;
                end else if (cfg_mode == MODE_2X) begin
                    cnt_a = a_moved && r.a;
                    cnt_b = b_moved && r.b;
                end else begin
                    cnt_a = a_moved;
                    cnt_b = b_moved;
                end
                if (cnt_a)
                    count_bank[bank_sel] += (r.a != r.b) ? 16'd1 : 16'hFFFF;
                if (cnt_b)
                    count_bank[bank_sel] += (r.a == r.b) ? 16'd1 : 16'hFFFF;
                last_a = r.a;
                last_b = r.b;
            end
            OP_CMD: begin
                case (r.code)
                    CMD_CLEAR: begin
                        count_bank[0] = '0;
                        count_bank[1] = '0;
                        bank_sel = 1'b0;
                        pend_cmd = CMD_OTHER;
                    end
                    CMD_MOTOR: begin
                        lvl = {1'b0, r.data} + {1'b0, cfg_offset};
                        pwm_level = lvl[BYTE_BITS] ? PWM_MAX : lvl[BYTE_BITS-1:0];
                        pend_cmd = CMD_OTHER;
                    end
                    default: pend_cmd = r.code;
                endcase
            end
            OP_READ: begin
                if (pend_cmd == CMD_READ) begin
                    v = count_bank[bank_sel];
                    count_bank[bank_sel] = '0;
                    bank_sel = ~bank_sel;
                    rep.value = cfg_invert ? -v : v;
                    rep.valid = 1'b1;
                end else if (pend_cmd == CMD_IDENT) begin
                    rep.value = {8'd0, cfg_version};
                    rep.valid = 1'b1;
                    rep.kind = 1'b1;
                end
                pend_cmd = CMD_OTHER;
            end
            default: ;
        endcase
        rep.pwm = pwm_level;
        return rep;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                reply_expect_q.push_back(predict_reply(req_on_bus));
                req_accepted <= req_accepted + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (req_queue.size() != 0 && (no_idle || $urandom_range(99) >= 21)) begin
                    req_on_bus = req_queue.pop_front();
                    i_s_tdata <= {3'd0, req_on_bus.data, req_on_bus.code,
                                  req_on_bus.b, req_on_bus.a};
                    i_s_tuser <= req_on_bus.op;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (rx_hold_cnt != 0) begin
            rx_hold_cnt <= rx_hold_cnt - 1;
        end else if (!hold_done && hold_at >= 0 && req_accepted >= hold_at) begin
            rx_hold_cnt <= 80;
            hold_done <= 1'b1;
        end
    end

    // reply monitor
    always @(posedge i_clk) begin
        t_reply exp_rep;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (reply_expect_q.size() == 0) begin
                $display("%0t: unexpected reply, actual %h kind %b", $time, o_m_tdata, o_m_tuser);
                err_count++;
            end else begin
                exp_rep = reply_expect_q.pop_front();
                if (o_m_tdata[0] !== exp_rep.valid) begin
                    $display("%0t: reply_valid expected %b actual %b",
                             $time, exp_rep.valid, o_m_tdata[0]);
                    err_count++;
                end
                if (o_m_tuser !== exp_rep.kind) begin
                    $display("%0t: reply_kind expected %b actual %b",
                             $time, exp_rep.kind, o_m_tuser);
                    err_count++;
                end
                if (o_m_tdata[REPLY_W:1] !== exp_rep.value) begin
                    $display("%0t: reply_value expected %h actual %h",
                             $time, exp_rep.value, o_m_tdata[REPLY_W:1]);
                    err_count++;
                end
                if (o_m_tdata[REPLY_W+BYTE_BITS:REPLY_W+1] !== exp_rep.pwm) begin
                    $display("%0t: pwm_level expected %h actual %h",
                             $time, exp_rep.pwm, o_m_tdata[REPLY_W+BYTE_BITS:REPLY_W+1]);
                    err_count++;
                end
            end
        end
        i_m_tready <= (rx_hold_cnt == 0) && (no_idle || $urandom_range(99) >= 21);
    end

    task automatic push_req(input logic [1:0] op, input logic a, input logic b,
                            input logic [2:0] code, input logic [BYTE_BITS-1:0] data);
        t_sample_req r;
        r = '{op: op, a: a, b: b, code: code, data: data};
        req_queue.push_back(r);
        if (op == OP_SAMPLE) begin
            pin_a = a;
            pin_b = b;
        end
    endtask

    task automatic push_sample(input logic a, input logic b);
        push_req(OP_SAMPLE, a, b, $urandom_range(7), $urandom_range(255));
    endtask

    task automatic push_cmd(input logic [2:0] code, input logic [BYTE_BITS-1:0] data);
        push_req(OP_CMD, $urandom_range(1), $urandom_range(1), code, data);
    endtask

    task automatic push_read();
        push_req(OP_READ, $urandom_range(1), $urandom_range(1),
                 $urandom_range(7), $urandom_range(255));
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [BYTE_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COUNT_MODE:  cfg_mode = val[1:0];
            CFG_INVERT_SIGN: cfg_invert = val[0];
            CFG_PWM_OFFSET:  cfg_offset = val;
            CFG_VERSION:     cfg_version = val;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic inv,
                              input logic [BYTE_BITS-1:0] ofs, input logic [BYTE_BITS-1:0] ver);
        cfg_write(CFG_COUNT_MODE, {6'd0, mode});
        cfg_write(CFG_INVERT_SIGN, {7'd0, inv});
        cfg_write(CFG_PWM_OFFSET, ofs);
        cfg_write(CFG_VERSION, ver);
    endtask

    task automatic wait_drained();
        while (req_queue.size() != 0 || i_s_tvalid || reply_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly clean quadrature walks and read sequences, some noise
    task automatic gen_traffic(input int n_req);
        int  start;
        int  pick;
        int  steps;
        bit  fwd;
        start = req_queue.size();
        while (req_queue.size() - start < n_req) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                steps = $urandom_range(1, 12);
                fwd = $urandom_range(1);
                repeat (steps) begin
                    if ($urandom_range(9) == 0)
                        push_sample($urandom_range(1), $urandom_range(1));
                    else if ((pin_a == pin_b) == fwd)
                        push_sample(~pin_a, pin_b);
                    else
                        push_sample(pin_a, ~pin_b);
                end
            end else if (pick < 66) begin
                push_cmd(CMD_READ, $urandom_range(255));
                if ($urandom_range(3) == 0)
                    push_sample(~pin_a, pin_b);
                push_read();
            end else if (pick < 73) begin
                push_cmd(CMD_IDENT, $urandom_range(255));
                push_read();
            end else if (pick < 81) begin
                push_cmd(CMD_MOTOR, ($urandom_range(3) == 0) ? 8'hFF : $urandom_range(255));
            end else if (pick < 84) begin
                push_cmd(CMD_CLEAR, $urandom_range(255));
            end else if (pick < 90) begin
                if ($urandom_range(1))
                    push_cmd($urandom_range(1) ? 3'd0 : $urandom_range(5, 7), $urandom_range(255));
                push_read();
            end else if (pick < 94) begin
                push_req(2'd3, $urandom_range(1), $urandom_range(1),
                         $urandom_range(7), $urandom_range(255));
            end else begin
                push_req($urandom_range(3), $urandom_range(1), $urandom_range(1),
                         $urandom_range(7), $urandom_range(255));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default 4x counting, no inversion, zero offset, version 1
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b1);
        push_cmd(CMD_READ, 8'h00);
        push_sample(1'b0, 1'b0);
        push_read();
        push_read();
        push_cmd(CMD_IDENT, 8'hFF);
        push_read();
        push_cmd(CMD_MOTOR, 8'hFF);
        push_cmd(CMD_MOTOR, 8'h00);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        push_cmd(CMD_CLEAR, 8'hAA);
        push_cmd(CMD_READ, 8'h55);
        push_read();
        push_cmd(3'd5, 8'h00);
        push_read();
        push_cmd(3'd7, 8'hFF);
        push_cmd(3'd6, 8'h00);
        push_cmd(CMD_OTHER, 8'h00);
        push_cmd(CMD_READ, 8'h00);
        push_req(2'd3, 1'b1, 1'b1, 3'd7, 8'hFF);
        push_read();
        wait_drained();

        set_config(MODE_1X, 1'b1, 8'hFF, 8'h00);
        gen_traffic(160);
        wait_drained();

        // back-to-back traffic with a long receiver stall
        set_config(MODE_2X, 1'b0, 8'h80, 8'hFF);
        no_idle = 1'b1;
        hold_at = req_accepted + 20;
        gen_traffic(160);
        wait_drained();
        no_idle = 1'b0;

        set_config(2'd3, 1'b1, 8'h01, 8'hA5);
        gen_traffic(160);
        wait_drained();

        set_config(MODE_4X, 1'b0, 8'h00, 8'h01);
        gen_traffic(160);
        wait_drained();

        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* quadrature_counter_read_clear.f */
hw/rtl/qcrc_pkg.sv
hw/rtl/qcrc_dir.sv
hw/rtl/qcrc_bank.sv
hw/rtl/quadrature_counter_read_clear.sv
tb/tb_quadrature_counter_read_clear.sv
